// ----- sv/pmsf_pkg.sv -----
// ----------------------------------------------------------------------------
// pmsf_pkg
// shared types and codes for the minimum spanning forest engine
// ----------------------------------------------------------------------------
`default_nettype none

package pmsf_pkg;

    localparam int IDX_W    = 6;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 24;
    localparam int SUM_W    = WEIGHT_W + 1;

    localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONNECT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // per-field write enables of the vertex memory
    typedef struct packed {
        logic weight;
        logic key;
        logic par;
        logic slot;
    } t_vwe;

    typedef enum logic [5:0] {
        S_IDLE,
        S_CN_RDA,
        S_CN_RDB,
        S_CN_SUM,
        S_CN_DIV,
        S_INIT,
        S_EXT_RD0,
        S_EXT_RDL,
        S_EXT_WR,
        S_SD_K,
        S_SD_KC,
        S_SD_CH,
        S_SD_LK,
        S_SD_LC,
        S_SD_RK,
        S_SD_RC,
        S_SD_DEC,
        S_SD_SW,
        S_UK_RD,
        S_UK_CHK,
        S_E_RD,
        S_E_CHK,
        S_RX_RD,
        S_RX_CHK,
        S_PS_RD,
        S_PS_CHK,
        S_KV_CHK,
        S_SU,
        S_SU_PS,
        S_SU_PK,
        S_SU_SW,
        S_RX_END,
        S_OUT_RD,
        S_OUT_EM
    } t_state;

endpackage

`default_nettype wire

// ----- sv/pmsf_div.sv -----
// ----------------------------------------------------------------------------
// pmsf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pmsf_div
    import pmsf_pkg::*;
#(
    parameter int KW = 40
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [KW-1:0]    i_dividend,
    input  wire logic [SUM_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [KW-1:0]         o_quotient
);

    localparam int CW = $clog2(KW + 1);

    logic            r_busy;
    logic [CW-1:0]   r_cnt;
    logic            r_done;
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_div;
    logic [KW-1:0]   r_quo;

    logic [SUM_W:0]   w_trial;
    logic             w_ge;
    logic [SUM_W-1:0] w_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[KW-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_rem   = w_ge ? SUM_W'(w_trial - {1'b0, r_div}) : w_trial[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(KW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_quo <= {r_quo[KW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- sv/pmsf_emem.sv -----
// ----------------------------------------------------------------------------
// pmsf_emem
// edge table: endpoints and cost, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pmsf_emem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int VW    = 6,
    parameter int KW    = 40
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [VW-1:0] i_wfrom,
    input  wire logic [VW-1:0] i_wto,
    input  wire logic [KW-1:0] i_wcost,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [VW-1:0] o_rfrom,
    output logic      [VW-1:0] o_rto,
    output logic      [KW-1:0] o_rcost
);

    logic [VW+VW+KW-1:0] mem [DEPTH];
    logic [VW+VW+KW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wfrom, i_wto, i_wcost};
        end
        r_rd <= mem[i_raddr];
    end

    assign {o_rfrom, o_rto, o_rcost} = r_rd;

endmodule

`default_nettype wire

// ----- sv/pmsf_vmem.sv -----
// ----------------------------------------------------------------------------
// pmsf_vmem
// vertex memory: weight, key, parent and heap slot per entry, field write enables
// ----------------------------------------------------------------------------
`default_nettype none

module pmsf_vmem
    import pmsf_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int KW    = 40
) (
    input  wire logic                i_clk,
    input  wire t_vwe                i_we,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire logic [WEIGHT_W-1:0] i_wweight,
    input  wire logic [KW-1:0]       i_wkey,
    input  wire logic                i_wphas,
    input  wire logic [AW-1:0]       i_wpidx,
    input  wire logic [AW-1:0]       i_wslot,
    input  wire logic [AW-1:0]       i_raddr,
    output logic      [WEIGHT_W-1:0] o_rweight,
    output logic      [KW-1:0]       o_rkey,
    output logic                     o_rphas,
    output logic      [AW-1:0]       o_rpidx,
    output logic      [AW-1:0]       o_rslot
);

    logic [WEIGHT_W-1:0] mem_weight [DEPTH];
    logic [KW-1:0]       mem_key    [DEPTH];
    logic [AW:0]         mem_par    [DEPTH];
    logic [AW-1:0]       mem_slot   [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.weight) begin
            mem_weight[i_waddr] <= i_wweight;
        end
        if (i_we.key) begin
            mem_key[i_waddr] <= i_wkey;
        end
        if (i_we.par) begin
            mem_par[i_waddr] <= {i_wphas, i_wpidx};
        end
        if (i_we.slot) begin
            mem_slot[i_waddr] <= i_wslot;
        end
        o_rweight            <= mem_weight[i_raddr];
        o_rkey               <= mem_key[i_raddr];
        {o_rphas, o_rpidx}   <= mem_par[i_raddr];
        o_rslot              <= mem_slot[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/prim_min_spanning_forest.sv -----
// ----------------------------------------------------------------------------
// prim_min_spanning_forest
// minimum spanning forest by prim's method over a binary min-heap in memory
// ----------------------------------------------------------------------------
// One item at a time; start is taken while busy is low and every result is
// shown for one cycle on o_valid, the receiver cannot stall. Add does not
// raise busy and its result follows in the next cycle. Connect, unless it is
// refused as missing or full, keeps busy high while the bit-serial divider
// works out the edge cost (skipped when both weights are zero), and its
// result comes as busy falls. Compute is bound by the single read port of the
// vertex and edge memories: an init pass over all V vertices, then per
// extracted vertex its extraction and sift-down plus a scan of every edge,
// and for an edge touching it a pair scan, heap search and sift-up; V
// results then follow. Each edge touches at most two extracted vertices.
// ----------------------------------------------------------------------------
`default_nettype none

module prim_min_spanning_forest
    import pmsf_pkg::*;
#(
    parameter int MAX_VERTICES  = 64,
    parameter int MAX_EDGES     = 256,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [MODE_W-1:0]   i_mode,
    input  wire logic [IDX_W-1:0]    i_vertex_a,
    input  wire logic [IDX_W-1:0]    i_vertex_b,
    input  wire logic [WEIGHT_W-1:0] i_tax,
    input  wire logic [DIST_W-1:0]   i_distance,
    output logic                     o_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [IDX_W-1:0]         o_child,
    output logic [IDX_W-1:0]         o_parent,
    output logic                     o_has_parent,
    output logic                     o_last
);

    localparam int KW  = DIST_W + FRACTION_BITS;
    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int PW  = VCW + 1;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam logic [KW-1:0] KEY_MAX = {KW{1'b1}};

    t_state              r_state, n_state;
    logic [VCW-1:0]      r_vcnt, n_vcnt;
    logic [ECW-1:0]      r_ecnt, n_ecnt;
    logic [VCW-1:0]      r_hsize, n_hsize;
    logic [PW-1:0]       r_i, n_i;
    logic [PW-1:0]       r_best, n_best;
    logic [ECW-1:0]      r_k, n_k;
    logic [ECW-1:0]      r_j, n_j;
    logic [VAW-1:0]      r_u, n_u;
    logic [VAW-1:0]      r_v, n_v;
    logic [VAW-1:0]      r_cv, n_cv;
    logic [VAW-1:0]      r_bv, n_bv;
    logic [VAW-1:0]      r_tv, n_tv;
    logic [VAW-1:0]      r_a, n_a;
    logic [VAW-1:0]      r_b, n_b;
    logic [KW-1:0]       r_ck, n_ck;
    logic [KW-1:0]       r_bk, n_bk;
    logic [KW-1:0]       r_cost, n_cost;
    logic [WEIGHT_W-1:0] r_wa, n_wa;
    logic [DIST_W-1:0]   r_dist, n_dist;

    logic                r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]    r_child, n_child;
    logic [IDX_W-1:0]    r_parent, n_parent;
    logic                r_has, n_has;
    logic                r_last, n_last;

    // vertex memory port
    t_vwe                v_we;
    logic [VAW-1:0]      v_waddr;
    logic [KW-1:0]       v_wkey;
    logic                v_wphas;
    logic [VAW-1:0]      v_wpidx;
    logic [VAW-1:0]      v_wslot;
    logic [VAW-1:0]      v_raddr;
    logic [WEIGHT_W-1:0] v_rweight;
    logic [KW-1:0]       v_rkey;
    logic                v_rphas;
    logic [VAW-1:0]      v_rpidx;
    logic [VAW-1:0]      v_rslot;

    // edge memory port
    logic                e_we;
    logic [KW-1:0]       e_wcost;
    logic [EAW-1:0]      e_raddr;
    logic [VAW-1:0]      e_rfrom;
    logic [VAW-1:0]      e_rto;
    logic [KW-1:0]       e_rcost;

    logic                div_start;
    logic                div_done;
    logic [KW-1:0]       div_quo;
    logic [SUM_W-1:0]    w_sum;

    logic [PW-1:0]       w_l, w_r, w_p;
    logic                w_accept;

    assign w_accept = start && !busy;
    assign w_l      = {r_i[VCW-1:0], 1'b1};
    assign w_r      = w_l + PW'(1);
    assign w_p      = (r_i - PW'(1)) >> 1;
    assign w_sum    = SUM_W'(r_wa) + SUM_W'(v_rweight);

    pmsf_vmem #(
        .DEPTH (MAX_VERTICES),
        .AW    (VAW),
        .KW    (KW)
    ) u_vmem (
        .i_clk     (i_clk),
        .i_we      (v_we),
        .i_waddr   (v_waddr),
        .i_wweight (i_tax),
        .i_wkey    (v_wkey),
        .i_wphas   (v_wphas),
        .i_wpidx   (v_wpidx),
        .i_wslot   (v_wslot),
        .i_raddr   (v_raddr),
        .o_rweight (v_rweight),
        .o_rkey    (v_rkey),
        .o_rphas   (v_rphas),
        .o_rpidx   (v_rpidx),
        .o_rslot   (v_rslot)
    );

    pmsf_emem #(
        .DEPTH (MAX_EDGES),
        .AW    (EAW),
        .VW    (VAW),
        .KW    (KW)
    ) u_emem (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_ecnt[EAW-1:0]),
        .i_wfrom (r_a),
        .i_wto   (r_b),
        .i_wcost (e_wcost),
        .i_raddr (e_raddr),
        .o_rfrom (e_rfrom),
        .o_rto   (e_rto),
        .o_rcost (e_rcost)
    );

    pmsf_div #(
        .KW (KW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (KW'(r_dist) << FRACTION_BITS),
        .i_divisor  (w_sum),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt  <= '0;
            r_ecnt  <= '0;
            r_hsize <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vcnt  <= n_vcnt;
            r_ecnt  <= n_ecnt;
            r_hsize <= n_hsize;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_best   <= n_best;
        r_k      <= n_k;
        r_j      <= n_j;
        r_u      <= n_u;
        r_v      <= n_v;
        r_cv     <= n_cv;
        r_bv     <= n_bv;
        r_tv     <= n_tv;
        r_a      <= n_a;
        r_b      <= n_b;
        r_ck     <= n_ck;
        r_bk     <= n_bk;
        r_cost   <= n_cost;
        r_wa     <= n_wa;
        r_dist   <= n_dist;
        r_status <= n_status;
        r_child  <= n_child;
        r_parent <= n_parent;
        r_has    <= n_has;
        r_last   <= n_last;
    end

    // the controller never uses a read taken in the cycle it writes the same entry
    always_comb begin
        n_state  = r_state;
        n_vcnt   = r_vcnt;
        n_ecnt   = r_ecnt;
        n_hsize  = r_hsize;
        n_i      = r_i;
        n_best   = r_best;
        n_k      = r_k;
        n_j      = r_j;
        n_u      = r_u;
        n_v      = r_v;
        n_cv     = r_cv;
        n_bv     = r_bv;
        n_tv     = r_tv;
        n_a      = r_a;
        n_b      = r_b;
        n_ck     = r_ck;
        n_bk     = r_bk;
        n_cost   = r_cost;
        n_wa     = r_wa;
        n_dist   = r_dist;
        n_valid  = 1'b0;
        n_status = ST_OK;
        n_child  = '0;
        n_parent = '0;
        n_has    = 1'b0;
        n_last   = 1'b1;

        v_we      = '0;
        v_waddr   = '0;
        v_wkey    = KEY_MAX;
        v_wphas   = 1'b0;
        v_wpidx   = '0;
        v_wslot   = '0;
        v_raddr   = '0;
        e_we      = 1'b0;
        e_wcost   = KEY_MAX;
        e_raddr   = r_k[EAW-1:0];
        div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_mode)
                        MODE_ADD: begin
                            n_valid = 1'b1;
                            if (r_vcnt >= VCW'(MAX_VERTICES)) begin
                                n_status = ST_FULL;
                            end else begin
                                v_we.weight = 1'b1;
                                v_waddr     = r_vcnt[VAW-1:0];
                                n_child     = IDX_W'(r_vcnt);
                                n_vcnt      = r_vcnt + VCW'(1);
                            end
                        end
                        MODE_CONNECT: begin
                            if ((IDX_W + 1)'(i_vertex_a) >= (IDX_W + 1)'(r_vcnt) ||
                                (IDX_W + 1)'(i_vertex_b) >= (IDX_W + 1)'(r_vcnt)) begin
                                n_valid  = 1'b1;
                                n_status = ST_MISSING;
                            end else if (r_ecnt >= ECW'(MAX_EDGES)) begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_a     = i_vertex_a[VAW-1:0];
                                n_b     = i_vertex_b[VAW-1:0];
                                n_dist  = i_distance;
                                n_state = S_CN_RDA;
                            end
                        end
                        MODE_COMPUTE: begin
                            if (r_vcnt != '0) begin
                                n_i     = '0;
                                n_state = S_INIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CN_RDA: begin
                v_raddr = r_a;
                n_state = S_CN_RDB;
            end
            S_CN_RDB: begin
                n_wa    = v_rweight;
                v_raddr = r_b;
                n_state = S_CN_SUM;
            end
            S_CN_SUM: begin
                if (w_sum == '0) begin
                    e_we     = 1'b1;
                    e_wcost  = KEY_MAX;
                    n_ecnt   = r_ecnt + ECW'(1);
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_CN_DIV;
                end
            end
            S_CN_DIV: begin
                if (div_done) begin
                    e_we    = 1'b1;
                    e_wcost = div_quo;
                    n_ecnt  = r_ecnt + ECW'(1);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_INIT: begin
                if (r_i < PW'(r_vcnt)) begin
                    v_we.key  = 1'b1;
                    v_we.par  = 1'b1;
                    v_we.slot = 1'b1;
                    v_waddr   = r_i[VAW-1:0];
                    v_wkey    = KEY_MAX;
                    v_wslot   = r_i[VAW-1:0];
                    n_i       = r_i + PW'(1);
                end else begin
                    n_hsize = r_vcnt;
                    n_state = S_EXT_RD0;
                end
            end
            S_EXT_RD0: begin
                v_raddr = '0;
                n_state = S_EXT_RDL;
            end
            S_EXT_RDL: begin
                n_u     = v_rslot;
                v_raddr = VAW'(r_hsize - VCW'(1));
                n_state = S_EXT_WR;
            end
            S_EXT_WR: begin
                // last slot moves to the root, then sifts down
                v_we.slot = 1'b1;
                v_waddr   = '0;
                v_wslot   = v_rslot;
                n_cv      = v_rslot;
                n_hsize   = r_hsize - VCW'(1);
                n_i       = '0;
                n_state   = S_SD_K;
            end
            S_SD_K: begin
                v_raddr = r_cv;
                n_state = S_SD_KC;
            end
            S_SD_KC: begin
                n_ck    = v_rkey;
                n_state = S_SD_CH;
            end
            S_SD_CH: begin
                n_best = r_i;
                n_bk   = r_ck;
                n_bv   = r_cv;
                if (w_l < PW'(r_hsize)) begin
                    v_raddr = w_l[VAW-1:0];
                    n_state = S_SD_LK;
                end else begin
                    n_state = S_SD_DEC;
                end
            end
            S_SD_LK: begin
                n_tv    = v_rslot;
                v_raddr = v_rslot;
                n_state = S_SD_LC;
            end
            S_SD_LC: begin
                if (v_rkey < r_bk) begin
                    n_best = w_l;
                    n_bk   = v_rkey;
                    n_bv   = r_tv;
                end
                if (w_r < PW'(r_hsize)) begin
                    v_raddr = w_r[VAW-1:0];
                    n_state = S_SD_RK;
                end else begin
                    n_state = S_SD_DEC;
                end
            end
            S_SD_RK: begin
                n_tv    = v_rslot;
                v_raddr = v_rslot;
                n_state = S_SD_RC;
            end
            S_SD_RC: begin
                if (v_rkey < r_bk) begin
                    n_best = w_r;
                    n_bv   = r_tv;
                end
                n_state = S_SD_DEC;
            end
            S_SD_DEC: begin
                if (r_best == r_i) begin
                    n_state = S_UK_RD;
                end else begin
                    v_we.slot = 1'b1;
                    v_waddr   = r_i[VAW-1:0];
                    v_wslot   = r_bv;
                    n_state   = S_SD_SW;
                end
            end
            S_SD_SW: begin
                v_we.slot = 1'b1;
                v_waddr   = r_best[VAW-1:0];
                v_wslot   = r_cv;
                n_i       = r_best;
                n_state   = S_SD_CH;
            end
            S_UK_RD: begin
                v_raddr = r_u;
                n_state = S_UK_CHK;
            end
            S_UK_CHK: begin
                // an unreached vertex starts a new tree
                if (v_rkey == KEY_MAX) begin
                    v_we.key = 1'b1;
                    v_waddr  = r_u;
                    v_wkey   = '0;
                end
                n_k     = '0;
                n_state = S_E_RD;
            end
            S_E_RD: begin
                e_raddr = r_k[EAW-1:0];
                if (r_k < r_ecnt) begin
                    n_state = S_E_CHK;
                end else if (r_hsize != '0) begin
                    n_state = S_EXT_RD0;
                end else begin
                    n_i     = '0;
                    n_state = S_OUT_RD;
                end
            end
            S_E_CHK: begin
                n_j = '0;
                if (e_rfrom == r_u) begin
                    n_v     = e_rto;
                    n_state = S_RX_RD;
                end else if (e_rto == r_u) begin
                    n_v     = e_rfrom;
                    n_state = S_RX_RD;
                end else begin
                    n_k     = r_k + ECW'(1);
                    n_state = S_E_RD;
                end
            end
            S_RX_RD: begin
                e_raddr = r_j[EAW-1:0];
                n_state = S_RX_CHK;
            end
            S_RX_CHK: begin
                // first edge in table order joining the pair sets the cost
                if ((e_rfrom == r_u && e_rto == r_v) ||
                    (e_rfrom == r_v && e_rto == r_u)) begin
                    n_cost  = e_rcost;
                    n_i     = '0;
                    n_state = S_PS_RD;
                end else begin
                    n_j     = r_j + ECW'(1);
                    n_state = S_RX_RD;
                end
            end
            S_PS_RD: begin
                if (r_i < PW'(r_hsize)) begin
                    v_raddr = r_i[VAW-1:0];
                    n_state = S_PS_CHK;
                end else begin
                    n_state = S_RX_END;
                end
            end
            S_PS_CHK: begin
                if (v_rslot == r_v) begin
                    v_raddr = r_v;
                    n_state = S_KV_CHK;
                end else begin
                    n_i     = r_i + PW'(1);
                    n_state = S_PS_RD;
                end
            end
            S_KV_CHK: begin
                if (r_cost < v_rkey) begin
                    v_we.key = 1'b1;
                    v_we.par = 1'b1;
                    v_waddr  = r_v;
                    v_wkey   = r_cost;
                    v_wphas  = 1'b1;
                    v_wpidx  = r_u;
                    n_state  = S_SU;
                end else begin
                    n_state = S_RX_END;
                end
            end
            S_SU: begin
                if (r_i == '0) begin
                    n_state = S_RX_END;
                end else begin
                    v_raddr = w_p[VAW-1:0];
                    n_state = S_SU_PS;
                end
            end
            S_SU_PS: begin
                n_tv    = v_rslot;
                v_raddr = v_rslot;
                n_state = S_SU_PK;
            end
            S_SU_PK: begin
                if (r_cost < v_rkey) begin
                    v_we.slot = 1'b1;
                    v_waddr   = r_i[VAW-1:0];
                    v_wslot   = r_tv;
                    n_state   = S_SU_SW;
                end else begin
                    n_state = S_RX_END;
                end
            end
            S_SU_SW: begin
                v_we.slot = 1'b1;
                v_waddr   = w_p[VAW-1:0];
                v_wslot   = r_v;
                n_i       = w_p;
                n_state   = S_SU;
            end
            S_RX_END: begin
                n_k     = r_k + ECW'(1);
                n_state = S_E_RD;
            end
            S_OUT_RD: begin
                v_raddr = r_i[VAW-1:0];
                n_state = S_OUT_EM;
            end
            S_OUT_EM: begin
                n_valid  = 1'b1;
                n_child  = IDX_W'(r_i);
                n_has    = v_rphas;
                n_parent = v_rphas ? IDX_W'(v_rpidx) : '0;
                n_last   = (r_i + PW'(1)) == PW'(r_vcnt);
                n_i      = r_i + PW'(1);
                n_state  = n_last ? S_IDLE : S_OUT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy         = r_state != S_IDLE;
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_child      = r_child;
    assign o_parent     = r_parent;
    assign o_has_parent = r_has;
    assign o_last       = r_last;

`ifndef SYNTH
    a_heap_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hsize <= r_vcnt)
        else $error("heap larger than vertex count");

    a_edges_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= ECW'(MAX_EDGES))
        else $error("edge count past table size");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("final result while still busy");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_CN_DIV))
        else $error("divider finished outside connect");

    a_root_empty_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_RD) |-> (r_hsize == '0))
        else $error("results started with vertices left in heap");
`endif

endmodule

`default_nettype wire
